### rtl/core/brf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg: shared definitions for the byte ring FIFO
// Widths, request and status codes, and the memory request bundle that the
// sequencer sends to the byte store.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Store geometry.
  localparam int BUFFER_DEPTH = 256;
  localparam int PTR_W        = $clog2(BUFFER_DEPTH);
  localparam int LEVEL_W      = PTR_W + 1;

  // Longest run that one pop request may return.
  localparam int MAX_RUN = 64;
  localparam int CNT_W   = 7;

  // Field widths of the input and result items.
  localparam int BYTE_W    = 8;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // Request codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELIM = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVR   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // One access to the byte store per cycle.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } brf_mem_req_t;

endpackage
`default_nettype wire

### rtl/core/byte_ring_fifo_with_delimiter_read.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_delimiter_read: byte ring FIFO with delimiter pops
// Sequencer, shared address unit and result register around the byte store.
// ----------------------------------------------------------------------------
// A write item stores one byte (dropping the oldest when the 256-byte ring is
// full). Its result enters the output register as the byte is written, which
// waits until the output slot is free. A run pop returns one result per byte,
// and each byte goes through the single registered read port of the store. A
// delimiter pop first scans for the stop byte (read, then compare, for each
// byte looked at), then pops through the match; a request that finds nothing
// gives one invalid result. One item is worked at a time: in_tready is high
// only while the sequencer is idle, though a finished result may still wait
// in the output register. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_delimiter_read
  import brf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // in_tdata: data_byte [7:0], count [14:8], stop_byte [22:15], zero [23]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: func [1:0]
  input  wire logic [FUNC_W-1:0]     in_tuser,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: out_byte [7:0], level [16:8], zero [23:17]
  output      logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: byte_valid [0], status [2:1]
  output      logic [OUT_USER_W-1:0] out_tuser,
  output      logic                  out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FAIL,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_POP_RD,
    ST_POP_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [LEVEL_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic [BYTE_W-1:0]  stop_r, stop_nxt;
  logic [CNT_W-1:0]   limit_r, limit_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_bvalid_r, out_bvalid_nxt;
  logic                out_last_r, out_last_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [LEVEL_W-1:0]  out_level_r, out_level_nxt;

  // Input field unpacking.
  logic [BYTE_W-1:0] in_data_byte;
  logic [CNT_W-1:0]  in_count;
  logic [BYTE_W-1:0] in_stop_byte;
  logic [CNT_W-1:0]  count_sat;
  logic [CNT_W-1:0]  in_limit;

  assign in_data_byte = in_tdata[7:0];
  assign in_count     = in_tdata[14:8];
  assign in_stop_byte = in_tdata[22:15];

  // Saturate count and bound it by the fill level.
  assign count_sat = (in_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : in_count;
  assign in_limit  = ({2'b00, count_sat} < fill_r) ? count_sat : fill_r[CNT_W-1:0];

  // Shared unit and store.
  brf_mem_req_t      mem_req;
  logic [BYTE_W-1:0] rd_byte;
  logic [PTR_W-1:0]  alu_base;
  logic [PTR_W-1:0]  alu_offset;
  logic [PTR_W-1:0]  alu_sum;
  logic              alu_match;

  brf_addr_unit u_addr_unit (
    .base      (alu_base),
    .offset    (alu_offset),
    .rd_byte   (rd_byte),
    .stop_byte (stop_r),
    .sum       (alu_sum),
    .match     (alu_match)
  );

  brf_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rd_byte)
  );

  logic slot_free;
  logic emit;
  logic full;
  logic run_done;

  assign slot_free = !out_valid_r || out_tready;
  assign full      = (fill_r == LEVEL_W'(BUFFER_DEPTH));
  assign run_done  = ((k_r + CNT_W'(1)) == n_r);
  assign in_tready = (state_r == ST_IDLE);

  // Operand selection for the shared unit.
  always_comb begin
    alu_base   = rp_r;
    alu_offset = '0;
    case (state_r)
      ST_WRITE: begin
        // A write into an empty ring restarts at the bottom of the store.
        alu_base   = (fill_r == '0) ? '0 : rp_r;
        alu_offset = fill_r[PTR_W-1:0];
      end
      ST_SCAN_RD:  alu_offset = {1'b0, k_r};
      ST_POP_EMIT: alu_offset = PTR_W'(1);
      default:     alu_offset = '0;
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    fill_nxt       = fill_r;
    data_nxt       = data_r;
    stop_nxt       = stop_r;
    limit_nxt      = limit_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    emit           = 1'b0;
    out_byte_nxt   = out_byte_r;
    out_bvalid_nxt = out_bvalid_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;
    mem_req.wr_en  = 1'b0;
    mem_req.rd_en  = 1'b0;
    mem_req.addr   = alu_sum;
    mem_req.wdata  = data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          data_nxt  = in_data_byte;
          stop_nxt  = in_stop_byte;
          limit_nxt = in_limit;
          k_nxt     = '0;
          n_nxt     = in_limit;
          if (in_tuser == FUNC_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (in_tuser == FUNC_RUN && in_limit != '0) begin
            state_nxt = ST_POP_RD;
          end else if (in_tuser == FUNC_DELIM && in_limit != '0) begin
            state_nxt = ST_SCAN_RD;
          end else begin
            state_nxt = ST_FAIL;
          end
        end
      end

      ST_WRITE: begin
        if (slot_free) begin
          mem_req.wr_en  = 1'b1;
          emit           = 1'b1;
          out_byte_nxt   = '0;
          out_bvalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          if (full) begin
            // Full ring: overwrite the oldest byte and move past it.
            rp_nxt         = rp_r + PTR_W'(1);
            out_status_nxt = STATUS_OVR;
            out_level_nxt  = fill_r;
          end else begin
            rp_nxt         = alu_base;
            fill_nxt       = fill_r + LEVEL_W'(1);
            out_status_nxt = STATUS_OK;
            out_level_nxt  = fill_r + LEVEL_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_FAIL: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_byte_nxt   = '0;
          out_bvalid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = STATUS_EMPTY;
          out_level_nxt  = fill_r;
          state_nxt      = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (alu_match) begin
          // Pop everything through the delimiter.
          n_nxt     = k_r + CNT_W'(1);
          k_nxt     = '0;
          state_nxt = ST_POP_RD;
        end else if ((k_r + CNT_W'(1)) == limit_r) begin
          state_nxt = ST_FAIL;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_POP_RD: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = ST_POP_EMIT;
      end

      ST_POP_EMIT: begin
        if (slot_free) begin
          emit           = 1'b1;
          out_byte_nxt   = rd_byte;
          out_bvalid_nxt = 1'b1;
          out_last_nxt   = run_done;
          out_status_nxt = STATUS_OK;
          out_level_nxt  = fill_r - LEVEL_W'(1);
          rp_nxt         = alu_sum;
          fill_nxt       = fill_r - LEVEL_W'(1);
          k_nxt          = k_r + CNT_W'(1);
          state_nxt      = run_done ? ST_IDLE : ST_POP_RD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State, pointers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    data_r       <= data_nxt;
    stop_r       <= stop_nxt;
    limit_r      <= limit_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    out_byte_r   <= out_byte_nxt;
    out_bvalid_r <= out_bvalid_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= out_level_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - LEVEL_W - BYTE_W){1'b0}}, out_level_r, out_byte_r};
  assign out_tuser  = {out_status_r, out_bvalid_r};
  assign out_tlast  = out_last_r;

  // The fill level never exceeds the store depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEVEL_W'(BUFFER_DEPTH))
    else $error("fill level above store depth");

  // A byte is only popped from a non-empty ring.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP_EMIT) |-> (fill_r != '0))
    else $error("pop from an empty ring");

  // A popped byte always carries the ok status.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_bvalid_nxt) |-> (out_status_nxt == STATUS_OK))
    else $error("popped byte with a non-ok status");

  // A result that is not the last of its run keeps the sequencer busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !out_last_nxt) |=> (state_r != ST_IDLE))
    else $error("run ended without a last result");

endmodule
`default_nettype wire

### rtl/core/brf_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_store: byte store of the ring FIFO
// Single-port memory; a read returns its data in the cycle after it is asked
// for, and the read register holds until the next read.
// ----------------------------------------------------------------------------
module brf_store
  import brf_pkg::*;
(
  input  wire logic              clk,
  input  wire brf_mem_req_t      req,
  output      logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [BUFFER_DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  // Write and registered read at the requested address.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/brf_addr_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brf_addr_unit: shared pointer adder and byte comparator
// Forms every store address and the pop pointer step as a wrapped sum, and compares
// the byte just read against the delimiter.
// ----------------------------------------------------------------------------
module brf_addr_unit
  import brf_pkg::*;
(
  input  wire logic [PTR_W-1:0]  base,
  input  wire logic [PTR_W-1:0]  offset,
  input  wire logic [BYTE_W-1:0] rd_byte,
  input  wire logic [BYTE_W-1:0] stop_byte,
  output      logic [PTR_W-1:0]  sum,
  output      logic              match
);

  // The sum wraps around the store depth by width.
  assign sum   = base + offset;
  assign match = (rd_byte == stop_byte);

endmodule
`default_nettype wire
